>>> rtl/dual_led_dimmer_fade_pdm_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the dual LED dimmer
// Shorthand for clocked, reset-qualified concurrent assertions.
// -----------------------------------------------------------------------------
`ifndef DUAL_LED_DIMMER_FADE_PDM_MACROS_SVH
`define DUAL_LED_DIMMER_FADE_PDM_MACROS_SVH

// same-cycle implication
`define DLD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/dld_pkg.sv
// -----------------------------------------------------------------------------
// dld_pkg
// Shared types and constants of the dual LED dimmer.
// -----------------------------------------------------------------------------
`default_nettype none

package dld_pkg;

   localparam int COMPARE_BITS = 16;
   localparam int CMP_W        = 16;
   localparam int LEVEL_W      = 17;
   localparam logic [CMP_W-1:0] CMP_MASK = CMP_W'((32'd1 << COMPARE_BITS) - 32'd1);
   localparam logic [LEVEL_W-1:0] FULL_LEVEL = 17'd65536;

   // truncating divide by the fade tick count: floor(a * FADE_RECIP / 2^FADE_SHIFT)
   localparam int FADE_TICKS = 25;
   localparam int FADE_SHIFT = 21;
   localparam logic [16:0] FADE_RECIP = 17'(((1 << FADE_SHIFT) + FADE_TICKS - 1) / FADE_TICKS);

   typedef enum logic [1:0] {
      FUNC_SET    = 2'd0,
      FUNC_TICK   = 2'd1,
      FUNC_PERIOD = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      REG_MAX_COMPARE = 2'd0,
      REG_MIN_COMPARE = 2'd1,
      REG_FADE_ENABLE = 2'd2,
      REG_NONE        = 2'd3
   } reg_type;

   typedef struct packed {
      logic             go;
      func_type         func;
      logic             rejected;
      logic             fade_en;
      logic [CMP_W-1:0] min_cmp;
   } op_type;

endpackage

`default_nettype wire

>>> rtl/dld_prep.sv
// -----------------------------------------------------------------------------
// dld_prep
// Scales both requested levels to compare units and flags out-of-range levels.
// -----------------------------------------------------------------------------
`default_nettype none

module dld_prep (
   input  wire logic [dld_pkg::LEVEL_W-1:0]         level_warm,
   input  wire logic [dld_pkg::LEVEL_W-1:0]         level_cold,
   input  wire logic [dld_pkg::CMP_W-1:0]           max_compare,
   output logic [1:0][dld_pkg::CMP_W-1:0]           value,
   output logic                                     rejected
);
   import dld_pkg::*;

   logic [CMP_W+LEVEL_W-1:0] prod_warm;
   logic [CMP_W+LEVEL_W-1:0] prod_cold;
   logic [CMP_W-1:0]         raw_warm;
   logic [CMP_W-1:0]         raw_cold;

   always_comb begin
      prod_warm = (CMP_W+LEVEL_W)'(max_compare) * (CMP_W+LEVEL_W)'(level_warm);
      prod_cold = (CMP_W+LEVEL_W)'(max_compare) * (CMP_W+LEVEL_W)'(level_cold);
      raw_warm  = prod_warm[CMP_W+15:16];
      raw_cold  = prod_cold[CMP_W+15:16];
      value[0]  = raw_warm;
      value[1]  = raw_cold;
      // lift a vanishing level to one count when it is not below the other level
      if (raw_warm == '0 && level_warm != '0 && level_warm >= level_cold) begin
         value[0] = CMP_W'(1);
      end
      if (raw_cold == '0 && level_cold != '0 && level_cold >= level_warm) begin
         value[1] = CMP_W'(1);
      end
      rejected = (level_warm > FULL_LEVEL) || (level_cold > FULL_LEVEL);
   end

endmodule

`default_nettype wire

>>> rtl/dld_chan.sv
// -----------------------------------------------------------------------------
// dld_chan
// One dimmer channel: set point, fade target and step, pulse density state.
// -----------------------------------------------------------------------------
`default_nettype none

module dld_chan (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire dld_pkg::op_type              op,
   input  wire logic                         wr_all,
   input  wire logic [dld_pkg::CMP_W-1:0]    value,
   output logic                              moved,
   output logic [dld_pkg::CMP_W-1:0]         nxt_point,
   output logic [dld_pkg::CMP_W-1:0]         nxt_compare,
   output logic                              nxt_fading
);
   import dld_pkg::*;

   logic [CMP_W-1:0]   point_ff,   point_in;
   logic [CMP_W-1:0]   target_ff,  target_in;
   logic signed [16:0] step_ff,    step_in;
   logic signed [17:0] acc_ff,     acc_in;
   logic [CMP_W-1:0]   prev_ff,    prev_in;
   logic [CMP_W-1:0]   cmp_ff,     cmp_in;

   logic signed [16:0] diff;
   logic [15:0]        mag;
   logic [32:0]        prod;
   logic [16:0]        quo;
   logic signed [16:0] set_step;
   logic signed [17:0] sum;
   logic signed [17:0] tgt_ext;
   logic               hit;
   logic [CMP_W-1:0]   tick_point;
   logic               dens_now;
   logic               dens_was;
   logic signed [17:0] acc_base;
   logic signed [17:0] acc_sub;
   logic               direct;

   assign moved = (op.func == FUNC_TICK) && op.fade_en && (point_ff != target_ff)
                  && (step_ff != '0);

   always_comb begin
      diff     = $signed({1'b0, value}) - $signed({1'b0, point_ff});
      mag      = diff[16] ? 16'(-diff) : diff[15:0];
      prod     = 33'(mag) * 33'(FADE_RECIP);
      quo      = 17'(prod[32:FADE_SHIFT]);
      set_step = diff[16] ? -$signed(quo) : $signed(quo);
      if (quo == '0 && diff != '0) begin
         set_step = diff[16] ? -17'sd1 : 17'sd1;
      end

      sum     = $signed({2'b00, point_ff}) + 18'(step_ff);
      tgt_ext = $signed({2'b00, target_ff});
      hit     = (step_ff > 0 && sum >= tgt_ext) || (step_ff < 0 && sum <= tgt_ext);

      dens_now = (point_ff != '0) && (point_ff < op.min_cmp);
      dens_was = (prev_ff != '0) && (prev_ff < op.min_cmp);
      acc_base = (dens_now != dens_was) ? '0 : acc_ff;
      acc_sub  = acc_base - $signed({2'b00, point_ff});
      direct   = (op.min_cmp <= CMP_W'(1));

      point_in   = point_ff;
      target_in  = target_ff;
      step_in    = step_ff;
      acc_in     = acc_ff;
      prev_in    = prev_ff;
      cmp_in     = cmp_ff;
      tick_point = point_ff;

      if (op.go) begin
         case (op.func)
            FUNC_SET: begin
               if (!op.rejected) begin
                  target_in = value;
                  if (op.fade_en) begin
                     step_in = set_step;
                  end else begin
                     step_in  = '0;
                     point_in = value;
                     if (direct) begin
                        cmp_in = value;
                     end
                  end
               end
            end
            FUNC_TICK: begin
               if (op.fade_en) begin
                  if (point_ff == target_ff) begin
                     step_in = '0;
                  end else if (step_ff != '0) begin
                     if (hit) begin
                        tick_point = target_ff;
                        step_in    = '0;
                     end else begin
                        tick_point = sum[CMP_W-1:0];
                     end
                  end
                  if (wr_all) begin
                     point_in = tick_point;
                     if (direct) begin
                        cmp_in = tick_point;
                     end
                  end
               end
            end
            FUNC_PERIOD: begin
               prev_in = point_ff;
               acc_in  = acc_base;
               if (dens_now) begin
                  if (acc_sub <= 0) begin
                     cmp_in = op.min_cmp;
                     acc_in = acc_sub + $signed({2'b00, op.min_cmp});
                  end else begin
                     cmp_in = '0;
                     acc_in = acc_sub;
                  end
               end else begin
                  cmp_in = point_ff;
               end
            end
            default: begin
            end
         endcase
      end

      nxt_point   = point_in;
      nxt_compare = cmp_in;
      nxt_fading  = (step_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_ff  <= '0;
         target_ff <= '0;
         step_ff   <= '0;
         acc_ff    <= '0;
         prev_ff   <= '0;
         cmp_ff    <= '0;
      end else begin
         point_ff  <= point_in;
         target_ff <= target_in;
         step_ff   <= step_in;
         acc_ff    <= acc_in;
         prev_ff   <= prev_in;
         cmp_ff    <= cmp_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/dual_led_dimmer_fade_pdm.sv
// -----------------------------------------------------------------------------
// Two-channel LED dimmer with linear fade and pulse skipping.
// A request enters an input register, where both levels are already scaled to
// compare units; once the output register is free or being emptied, the channel
// state updates and the response is loaded into the output register. One request
// is taken every cycle, limited only by the response side: the input register
// keeps accepting while a response waits to be taken, and stops only when both
// the input and output registers are full and the response is not being taken.
// -----------------------------------------------------------------------------
`default_nettype none

module dual_led_dimmer_fade_pdm (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // level_warm[16:0], level_cold[33:17], zero
   input  wire logic [1:0]  req_tuser,   // func[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // compare_warm[15:0], compare_cold[31:16],
                                         // point_warm[47:32], point_cold[63:48],
                                         // fading[64], rejected[65], zero
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import dld_pkg::*;

   logic [CMP_W-1:0]        max_cmp_ff;
   logic [CMP_W-1:0]        min_cmp_ff;
   logic                    fade_en_ff;

   logic [1:0][CMP_W-1:0]   prep_value;
   logic                    prep_rejected;

   logic                    s1_valid_ff;
   func_type                s1_func_ff;
   logic [1:0][CMP_W-1:0]   s1_value_ff;
   logic                    s1_rej_ff;

   logic                    rsp_valid_ff;
   logic [71:0]             rsp_data_ff;

   logic                    advance;
   op_type                  op;
   logic                    wr_all;
   logic                    moved_warm,   moved_cold;
   logic [CMP_W-1:0]        point_warm,   point_cold;
   logic [CMP_W-1:0]        cmp_warm,     cmp_cold;
   logic                    fading_warm,  fading_cold;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_cmp_ff <= CMP_W'(1023) & CMP_MASK;
         min_cmp_ff <= CMP_W'(1);
         fade_en_ff <= 1'b0;
      end else if (csr_we) begin
         case (reg_type'(csr_index))
            REG_MAX_COMPARE: max_cmp_ff <= csr_wdata & CMP_MASK;
            REG_MIN_COMPARE: min_cmp_ff <= csr_wdata & CMP_MASK;
            REG_FADE_ENABLE: fade_en_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   dld_prep u_prep (
      .level_warm  (req_tdata[16:0]),
      .level_cold  (req_tdata[33:17]),
      .max_compare (max_cmp_ff),
      .value       (prep_value),
      .rejected    (prep_rejected)
   );

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_func_ff  <= func_type'(req_tuser);
         s1_value_ff <= prep_value;
         s1_rej_ff   <= prep_rejected;
      end
   end

   always_comb begin
      op.go       = advance;
      op.func     = s1_func_ff;
      op.rejected = s1_rej_ff;
      op.fade_en  = fade_en_ff;
      op.min_cmp  = min_cmp_ff;
   end

   assign wr_all = moved_warm || moved_cold;

   dld_chan u_warm (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .wr_all      (wr_all),
      .value       (s1_value_ff[0]),
      .moved       (moved_warm),
      .nxt_point   (point_warm),
      .nxt_compare (cmp_warm),
      .nxt_fading  (fading_warm)
   );

   dld_chan u_cold (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .wr_all      (wr_all),
      .value       (s1_value_ff[1]),
      .moved       (moved_cold),
      .nxt_point   (point_cold),
      .nxt_compare (cmp_cold),
      .nxt_fading  (fading_cold)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {6'b0,
                         (s1_func_ff == FUNC_SET) && s1_rej_ff,
                         fading_warm || fading_cold,
                         point_cold, point_warm, cmp_cold, cmp_warm};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/dld_checker.sv
// -----------------------------------------------------------------------------
// dld_checker
// Port-level checks of the dual LED dimmer, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

`include "dual_led_dimmer_fade_pdm_macros.svh"

module dld_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata
);

   `DLD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response dropped or changed while stalled")

   `DLD_ASSERT_NEXT(a_rsp_follows, clock, reset, req_tvalid && req_tready, ##1 rsp_tvalid, "accepted request produced no response")

   `DLD_ASSERT_SAME(a_stall_cause, clock, reset, !req_tready, rsp_tvalid && !rsp_tready, "request side stalled without output backpressure")

   `DLD_ASSERT_SAME(a_tail_zero, clock, reset, rsp_tvalid, rsp_tdata[71:66] == 6'b0, "response padding not zero")

endmodule

bind dual_led_dimmer_fade_pdm dld_checker u_dld_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> bench/dimmer_checker.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Dimmer response checker
// Watches the request, response and register channels of the two-channel LED
// dimmer. It keeps its own copy of the set points, fade state, pulse-skipping
// accumulators and registers. For every accepted request it computes the
// expected response, and it compares each accepted response field by field
// against the oldest outstanding one.
// -----------------------------------------------------------------------------
module dimmer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   import dld_pkg::*;

   typedef struct packed {
      logic [15:0] cmp_w;
      logic [15:0] cmp_c;
      logic [15:0] pt_w;
      logic [15:0] pt_c;
      logic        fading;
      logic        rejected;
   } dimmer_rsp_type;

   dimmer_rsp_type expected_rsp_q [$];

   logic [15:0] max_cmp;
   logic [15:0] min_cmp;
   logic        fade_on;
   logic [15:0] point    [0:1];
   logic [15:0] target   [0:1];
   logic [15:0] prev_pt  [0:1];
   logic [15:0] cmp_val  [0:1];
   int          step     [0:1];
   int          skip_acc [0:1];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic bit in_skip_mode(logic [15:0] p);
      return p != 16'd0 && p < min_cmp;
   endfunction

   function automatic void load_points(logic [15:0] w, logic [15:0] c);
      point[0] = w;
      point[1] = c;
      if (min_cmp <= 16'd1) begin
         cmp_val[0] = w;
         cmp_val[1] = c;
      end
   endfunction

   function automatic dimmer_rsp_type advance_dimmer(func_type f, logic [16:0] lw,
                                                     logic [16:0] lc);
      dimmer_rsp_type r;
      logic [16:0] lv  [0:1];
      logic [15:0] val [0:1];
      logic [32:0] prod;
      int          d;
      int          np  [0:1];
      bit          moved;
      bit          skip_now;
      lv[0] = lw;
      lv[1] = lc;
      r.rejected = 1'b0;
      case (f)
         FUNC_SET: begin
            if (lw > FULL_LEVEL || lc > FULL_LEVEL) begin
               r.rejected = 1'b1;
            end else begin
               for (int ch = 0; ch < 2; ch++) begin
                  prod = {17'd0, max_cmp} * {16'd0, lv[ch]};
                  val[ch] = prod[31:16];
               end
               if (val[0] == 16'd0 && lv[0] != 17'd0 && lv[0] >= lv[1]) val[0] = 16'd1;
               if (val[1] == 16'd0 && lv[1] != 17'd0 && lv[1] >= lv[0]) val[1] = 16'd1;
               if (fade_on) begin
                  for (int ch = 0; ch < 2; ch++) begin
                     d = int'(val[ch]) - int'(point[ch]);
                     step[ch] = d / FADE_TICKS;
                     if (step[ch] == 0 && d != 0) step[ch] = (d > 0) ? 1 : -1;
                     target[ch] = val[ch];
                  end
               end else begin
                  for (int ch = 0; ch < 2; ch++) begin
                     target[ch] = val[ch];
                     step[ch]   = 0;
                  end
                  load_points(val[0], val[1]);
               end
            end
         end
         FUNC_TICK: begin
            if (fade_on) begin
               moved = 1'b0;
               for (int ch = 0; ch < 2; ch++) begin
                  np[ch] = int'(point[ch]);
                  if (np[ch] == int'(target[ch])) begin
                     step[ch] = 0;
                  end else if (step[ch] != 0) begin
                     moved = 1'b1;
                     np[ch] += step[ch];
                     if ((step[ch] > 0 && np[ch] >= int'(target[ch])) ||
                         (step[ch] < 0 && np[ch] <= int'(target[ch]))) begin
                        np[ch]   = int'(target[ch]);
                        step[ch] = 0;
                     end
                  end
               end
               if (moved) load_points(np[0][15:0], np[1][15:0]);
            end
         end
         FUNC_PERIOD: begin
            for (int ch = 0; ch < 2; ch++) begin
               skip_now = in_skip_mode(point[ch]);
               if (skip_now != in_skip_mode(prev_pt[ch])) skip_acc[ch] = 0;
               prev_pt[ch] = point[ch];
               if (skip_now) begin
                  skip_acc[ch] -= int'(point[ch]);
                  if (skip_acc[ch] <= 0) begin
                     cmp_val[ch]   = min_cmp;
                     skip_acc[ch] += int'(min_cmp);
                  end else begin
                     cmp_val[ch] = 16'd0;
                  end
               end else begin
                  cmp_val[ch] = point[ch];
               end
            end
         end
         default: ;
      endcase
      r.cmp_w  = cmp_val[0];
      r.cmp_c  = cmp_val[1];
      r.pt_w   = point[0];
      r.pt_c   = point[1];
      r.fading = (step[0] != 0 || step[1] != 0);
      return r;
   endfunction

   task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      dimmer_rsp_type got;
      dimmer_rsp_type want;
      if (reset) begin
         max_cmp = 16'd1023;
         min_cmp = 16'd1;
         fade_on = 1'b0;
         for (int ch = 0; ch < 2; ch++) begin
            point[ch]    = 16'd0;
            target[ch]   = 16'd0;
            prev_pt[ch]  = 16'd0;
            cmp_val[ch]  = 16'd0;
            step[ch]     = 0;
            skip_acc[ch] = 0;
         end
         expected_rsp_q.delete();
      end else begin
         if (csr_we) begin
            case (reg_type'(csr_index))
               REG_MAX_COMPARE: max_cmp = csr_wdata & CMP_MASK;
               REG_MIN_COMPARE: min_cmp = csr_wdata & CMP_MASK;
               REG_FADE_ENABLE: fade_on = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_rsp_q.push_back(advance_dimmer(func_type'(req_tuser),
                                                    req_tdata[16:0], req_tdata[33:17]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.cmp_w    = rsp_tdata[15:0];
            got.cmp_c    = rsp_tdata[31:16];
            got.pt_w     = rsp_tdata[47:32];
            got.pt_c     = rsp_tdata[63:48];
            got.fading   = rsp_tdata[64];
            got.rejected = rsp_tdata[65];
            if (expected_rsp_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response: expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = expected_rsp_q.pop_front();
               compare_field("compare_warm", want.cmp_w, got.cmp_w);
               compare_field("compare_cold", want.cmp_c, got.cmp_c);
               compare_field("point_warm", want.pt_w, got.pt_w);
               compare_field("point_cold", want.pt_c, got.pt_c);
               compare_field("fading", 16'(want.fading), 16'(got.fading));
               compare_field("rejected", 16'(want.rejected), 16'(got.rejected));
            end
         end
      end
      pending <= expected_rsp_q.size();
   end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Dual LED dimmer testbench
// Drives set, fade tick, period start and no-op requests into the dimmer with
// random gaps on the request side and random stalls on the response side,
// across several register settings. A checker beside the block predicts and
// compares every response; this module gives the verdict.
// -----------------------------------------------------------------------------
module tb_top;
   import dld_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int ITEMS_PER_PHASE = 105;
   localparam int RANDOM_PHASES = 10;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // level_warm[16:0], level_cold[33:17], zero
   logic [1:0]  req_tuser;    // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;    // compare_warm, compare_cold, point_warm, point_cold,
                              // fading[64], rejected[65], zero
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;
   int          fail_count;
   int          pending;
   int          idle_cycles = 0;
   int          sent = 0;
   int          rejects_sent = 0;
   int          settings = 0;
   bit          quiet = 1'b0;

   always #5 clock = ~clock;

   dual_led_dimmer_fade_pdm u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   dimmer_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   function automatic int pick_gap(bit no_idle);
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [16:0] pick_level();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 17'd0;
      if (r < 20) return FULL_LEVEL;
      if (r < 40) return 17'($urandom_range(1, 1024));
      if (r < 44) return 17'($urandom_range(65537, 131071));
      return 17'($urandom_range(0, 65536));
   endfunction

   // response side: bursts of ready with random stalls in between
   initial begin : rsp_ready_gen
      int run;
      int gap;
      forever begin
         rsp_tready <= 1'b1;
         run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(30, 120);
         repeat (run) @(posedge clock);
         gap = pick_gap(1'b0);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles at %0t", idle_cycles, $time);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_request(func_type f, logic [16:0] lw, logic [16:0] lc);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {6'd0, lc, lw};
      do @(posedge clock); while (!req_tready);
      sent++;
      if (f == FUNC_SET && (lw > FULL_LEVEL || lc > FULL_LEVEL)) rejects_sent++;
      gap = pick_gap(quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic csr_write(reg_type idx, logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic apply_settings(logic [15:0] mx, logic [15:0] mn, logic fe);
      drain_responses();
      csr_write(REG_MAX_COMPARE, mx);
      csr_write(REG_MIN_COMPARE, mn);
      csr_write(REG_FADE_ENABLE, (16'($urandom) & 16'hFFFE) | 16'(fe));
      if ($urandom_range(0, 3) == 0) csr_write(REG_NONE, 16'($urandom));
      csr_we <= 1'b0;
      settings++;
   endtask

   task automatic run_directed();
      // reset settings: full-scale 1023, no pulse skipping, no fade
      send_request(FUNC_SET, 17'd0, 17'd0);
      send_request(FUNC_SET, FULL_LEVEL, FULL_LEVEL);
      send_request(FUNC_PERIOD, 17'd0, 17'd0);
      send_request(FUNC_SET, 17'd65537, 17'd0);
      send_request(FUNC_SET, 17'd0, 17'h1FFFF);
      send_request(FUNC_SET, 17'd1, 17'd0);
      send_request(FUNC_SET, 17'd1, 17'd1);
      send_request(FUNC_SET, 17'd1, 17'd2);
      send_request(FUNC_TICK, 17'd0, 17'd0);
      send_request(FUNC_NOP, 17'h1FFFF, 17'h1FFFF);
      send_request(FUNC_SET, 17'd32768, 17'd16384);
      send_request(FUNC_PERIOD, 17'd0, 17'd0);
      // fade up and down, small steps and pulse skipping on the cold channel
      apply_settings(16'd65535, 16'd40, 1'b1);
      send_request(FUNC_SET, FULL_LEVEL, 17'd64);
      send_request(FUNC_TICK, 17'd0, 17'd0);
      send_request(FUNC_TICK, 17'd0, 17'd0);
      send_request(FUNC_PERIOD, 17'd0, 17'd0);
      send_request(FUNC_SET, 17'd0, 17'd64);
      send_request(FUNC_TICK, 17'd0, 17'd0);
      send_request(FUNC_PERIOD, 17'd0, 17'd0);
      send_request(FUNC_PERIOD, 17'd0, 17'd0);
      send_request(FUNC_PERIOD, 17'd0, 17'd0);
      // smallest full scale: a level that scales to zero rounds up, then leave skip mode
      apply_settings(16'd3, 16'd3, 1'b0);
      send_request(FUNC_SET, 17'd21845, 17'd1);
      send_request(FUNC_PERIOD, 17'd0, 17'd0);
      send_request(FUNC_PERIOD, 17'd0, 17'd0);
      send_request(FUNC_PERIOD, 17'd0, 17'd0);
      send_request(FUNC_SET, FULL_LEVEL, FULL_LEVEL);
      send_request(FUNC_PERIOD, 17'd0, 17'd0);
   endtask

   task automatic run_random_phase(int ph);
      int          r;
      int          mx;
      int          mn;
      logic        fe;
      func_type    f;
      logic [16:0] lw;
      logic [16:0] lc;
      case (ph)
         0: begin mx = 65535; mn = 1;     fe = 1'b0; end
         1: begin mx = 3;     mn = 1;     fe = 1'b1; end
         2: begin mx = 65535; mn = 65535; fe = 1'b1; end
         3: begin mx = 1023;  mn = 1;     fe = 1'b1; end
         default: begin
            r  = $urandom_range(0, 99);
            mx = (r < 20) ? 3 : (r < 40) ? 65535 : $urandom_range(3, 65535);
            r  = $urandom_range(0, 99);
            mn = (r < 30) ? 1 : (r < 40) ? 65535 : (r < 50) ? mx :
                 $urandom_range(1, (mx >> 2) + 1);
            fe = 1'($urandom_range(0, 1));
         end
      endcase
      apply_settings(16'(mx), 16'(mn), fe);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
         if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         f = (r < 15) ? FUNC_SET : (r < 55) ? FUNC_TICK : (r < 90) ? FUNC_PERIOD : FUNC_NOP;
         if (f == FUNC_SET) begin
            lw = pick_level();
            lc = pick_level();
         end else begin
            lw = 17'($urandom_range(0, 131071));
            lc = 17'($urandom_range(0, 131071));
         end
         send_request(f, lw, lc);
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= FUNC_NOP;
      csr_we     <= 1'b0;
      csr_index  <= REG_NONE;
      csr_wdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int ph = 0; ph < RANDOM_PHASES; ph++) run_random_phase(ph);
      drain_responses();
      repeat (8) @(posedge clock);
      $display("Summary: %0d requests (%0d out-of-range sets) over %0d register settings",
               sent, rejects_sent, settings);
      $display("Summary: fade on and off, pulse skipping up to full min_compare, stalls on both channels");
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
